[rtl/fpa_pkg.sv]
`default_nettype none
package fpa_pkg;

  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int WORD_BITS_DEFAULT = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MIN = 3'd4;
  localparam logic [2:0] OP_MAX = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_DIVZ  = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } request_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
    logic               a_less;
    logic               a_equal;
  } response_t;

endpackage
`default_nettype wire

[rtl/fpa_div.sv]
`default_nettype none
module fpa_div import fpa_pkg::*; #(
  parameter int EW        = WORD_BITS_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic [EW-1:0] mag_a,
  input  wire logic [EW-1:0] mag_b,
  input  wire logic          neg,
  output logic [EW+FRAC_BITS:0] quot,
  output logic               quot_neg
);

  localparam int N = EW + FRAC_BITS;

  logic [EW-1:0] rem [0:N];
  logic [N-1:0]  quo [0:N];
  logic [N-1:0]  dvd [0:N];
  logic [EW-1:0] dsr [0:N];
  logic          ng  [0:N];

  assign rem[0] = '0;
  assign quo[0] = '0;
  assign dvd[0] = N'(mag_a) << FRAC_BITS;
  assign dsr[0] = mag_b;
  assign ng[0]  = neg;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [EW:0] trial;
    logic        ge;
    assign trial = {rem[i], dvd[i][N-1]};
    assign ge    = trial >= {1'b0, dsr[i]};
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? EW'(trial - {1'b0, dsr[i]}) : trial[EW-1:0];
      quo[i+1] <= {quo[i][N-2:0], ge};
      dvd[i+1] <= dvd[i] << 1;
      dsr[i+1] <= dsr[i];
      ng[i+1]  <= ng[i];
    end
  end

  logic up;
  assign up = {1'b0, rem[N]} >= ({1'b0, dsr[N]} - {1'b0, rem[N]});

  always_ff @(posedge clk) begin
    quot     <= {1'b0, quo[N]} + (N+1)'(up);
    quot_neg <= ng[N];
  end

endmodule
`default_nettype wire

[rtl/fixed_point_alu_core.sv]
`default_nettype none
// Signed fixed-point ALU: add, subtract, multiply, divide, minimum, maximum
// on raw words of WORD_BITS (at most 32 used) with FRAC_BITS fraction bits.
// Input channel: request is taken at a clock edge where start is high and
// busy is low. busy stays low: a new request may be given every cycle.
// Output channel: response is valid for one cycle while done is high; the
// receiver cannot stall, so every transfer completes in that cycle.
// Throughput one item per cycle. Latency is the same for every operation
// and is set by the restoring divider, one quotient bit per stage; the
// other operations ride a delay line alongside it.
// Multiply and divide round half away from zero; overflow saturates with
// status 1; divide by zero gives result 0 and status 2.
// Reset clears all valid bits; items in flight are dropped.
module fixed_point_alu_core import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire request_t request,
  output logic      done,
  output response_t response
);

  localparam int EW = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int N  = EW + FRAC_BITS;
  localparam int CW = (2*EW + 2 > N + 2) ? 2*EW + 2 : N + 2;
  localparam logic [2*EW:0] RND = (FRAC_BITS > 0) ?
    ((2*EW+1)'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
  localparam logic [EW-1:0] WMIN = EW'(1) << (EW - 1);
  localparam logic [EW-1:0] WMAX = ~WMIN;

  typedef struct packed {
    logic [2:0]    op;
    logic [EW-1:0] res;
    logic [1:0]    st;
    logic          lt;
    logic          eq;
  } side_t;

  function automatic logic [EW:0] sat_mag(input logic neg, input logic [CW-1:0] mag);
    logic [CW-1:0] half;
    half = CW'(1) << (EW - 1);
    if (neg) begin
      if (mag > half) return {1'b1, WMIN};
      return {1'b0, EW'(~mag[EW-1:0] + EW'(1))};
    end
    if (mag > half - CW'(1)) return {1'b1, WMAX};
    return {1'b0, mag[EW-1:0]};
  endfunction

  assign busy = 1'b0;

  // input stage
  logic signed [EW-1:0] a_in, b_in;
  assign a_in = request.operand_a[EW-1:0];
  assign b_in = request.operand_b[EW-1:0];

  logic                 v0;
  logic [2:0]           op0;
  logic signed [EW-1:0] a0, b0;
  logic [EW-1:0]        ma0, mb0;
  logic                 neg0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start;
    op0  <= request.operation;
    a0   <= a_in;
    b0   <= b_in;
    ma0  <= a_in[EW-1] ? EW'(~a_in + EW'(1)) : a_in;
    mb0  <= b_in[EW-1] ? EW'(~b_in + EW'(1)) : b_in;
    neg0 <= a_in[EW-1] ^ b_in[EW-1];
  end

  // stage 1: product, sums, compares
  logic                 v1;
  logic [2:0]           op1;
  logic [2*EW-1:0]      prod1;
  logic signed [EW:0]   sum1, dif1;
  logic                 lt1, eq1, neg1, bz1;
  logic [EW-1:0]        mn1, mx1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
    op1   <= op0;
    prod1 <= ma0 * mb0;
    sum1  <= (EW+1)'(a0) + (EW+1)'(b0);
    dif1  <= (EW+1)'(a0) - (EW+1)'(b0);
    lt1   <= a0 < b0;
    eq1   <= a0 == b0;
    mn1   <= (a0 <= b0) ? a0 : b0;
    mx1   <= (a0 >= b0) ? a0 : b0;
    neg1  <= neg0;
    bz1   <= mb0 == '0;
  end

  // stage 2: rounding and saturation of the non-divide ops, divide-by-zero status
  logic [2*EW:0] mrnd;
  logic [CW-1:0] mq;
  logic [EW:0]   msat;
  side_t         s2;

  assign mrnd = {1'b0, prod1} + RND;
  assign mq   = CW'(mrnd >> FRAC_BITS);
  assign msat = sat_mag(neg1 && (mq != '0), mq);

  always_comb begin
    s2 = '{op: op1, res: '0, st: ST_OK, lt: lt1, eq: eq1};
    unique case (op1)
      OP_ADD: begin
        if (sum1[EW] != sum1[EW-1]) begin
          s2.res = sum1[EW] ? WMIN : WMAX;
          s2.st  = ST_SAT;
        end else begin
          s2.res = sum1[EW-1:0];
        end
      end
      OP_SUB: begin
        if (dif1[EW] != dif1[EW-1]) begin
          s2.res = dif1[EW] ? WMIN : WMAX;
          s2.st  = ST_SAT;
        end else begin
          s2.res = dif1[EW-1:0];
        end
      end
      OP_MUL: begin
        s2.res = msat[EW-1:0];
        s2.st  = msat[EW] ? ST_SAT : ST_OK;
      end
      OP_DIV: s2.st = bz1 ? ST_DIVZ : ST_OK;
      OP_MIN: s2.res = mn1;
      OP_MAX: s2.res = mx1;
      default: s2.res = '0;
    endcase
  end

  side_t        side [0:N-1];
  logic [N-1:0] vside;

  always_ff @(posedge clk) begin
    if (rst) vside <= '0;
    else     vside <= {vside[N-2:0], v1};
    side[0] <= s2;
  end

  for (genvar i = 1; i < N; i++) begin : g_delay
    always_ff @(posedge clk) side[i] <= side[i-1];
  end

  logic [N:0] quot;
  logic       quot_neg;

  fpa_div #(.EW(EW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .mag_a    (ma0),
    .mag_b    (mb0),
    .neg      (neg0),
    .quot     (quot),
    .quot_neg (quot_neg)
  );

  // output stage
  logic [CW-1:0] dq;
  logic [EW:0]   dsat;
  side_t         sl;
  logic [EW-1:0] res_w;
  logic [1:0]    st_w;

  assign sl   = side[N-1];
  assign dq   = CW'(quot);
  assign dsat = sat_mag(quot_neg && (dq != '0), dq);

  always_comb begin
    res_w = sl.res;
    st_w  = sl.st;
    if (sl.op == OP_DIV && sl.st != ST_DIVZ) begin
      res_w = dsat[EW-1:0];
      st_w  = dsat[EW] ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vside[N-1];
    response.result  <= 32'($signed(res_w));
    response.status  <= st_w;
    response.a_less  <= sl.lt;
    response.a_equal <= sl.eq;
  end

endmodule
`default_nettype wire

[dv/fixed_point_alu_core_tb.sv]
`timescale 1ns / 100ps
module fixed_point_alu_core_tb;
  import fpa_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam int LATENCY = 32 + FRAC + 2;
  localparam int N_RANDOM = 830;
  localparam longint CYCLE_LIMIT = 200000;

  class alu_scoreboard;
    response_t pending[$];
    int mismatches;
    int received;

    function new();
      mismatches = 0;
      received = 0;
    endfunction

    function automatic longint sat_mag(bit neg, longint unsigned mag, ref logic [1:0] st);
      if (neg) begin
        if (mag > 64'h8000_0000) begin
          st = ST_SAT;
          return -64'sh8000_0000;
        end
        return -longint'(mag);
      end
      if (mag > 64'h7fff_ffff) begin
        st = ST_SAT;
        return 64'sh7fff_ffff;
      end
      return longint'(mag);
    endfunction

    function automatic response_t compute(request_t rq);
      response_t rs;
      longint a, b, r, v;
      longint unsigned ma, mb, m, q, rem;
      logic [1:0] st;
      bit neg;
      a = rq.operand_a;
      b = rq.operand_b;
      st = ST_OK;
      r = 0;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      case (rq.operation)
        OP_ADD: begin
          v = a + b;
          r = sat_mag(v < 0, (v < 0) ? -v : v, st);
        end
        OP_SUB: begin
          v = a - b;
          r = sat_mag(v < 0, (v < 0) ? -v : v, st);
        end
        OP_MUL: begin
          m = ma * mb;
          if (FRAC > 0) m += 64'd1 << (FRAC - 1);
          q = m >> FRAC;
          r = sat_mag(neg && q != 0, q, st);
        end
        OP_DIV: begin
          if (mb == 0) begin
            st = ST_DIVZ;
            r = 0;
          end else begin
            m = ma << FRAC;
            q = m / mb;
            rem = m % mb;
            if (rem >= mb - rem) q++;
            r = sat_mag(neg && q != 0, q, st);
          end
        end
        OP_MIN: r = (a <= b) ? a : b;
        OP_MAX: r = (a >= b) ? a : b;
        default: r = 0;
      endcase
      rs.result = r[31:0];
      rs.status = st;
      rs.a_less = a < b;
      rs.a_equal = a == b;
      return rs;
    endfunction

    function void note_request(request_t rq);
      pending.push_back(compute(rq));
    endfunction

    function void check_response(response_t got);
      response_t exp_rs;
      received++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      exp_rs = pending.pop_front();
      if (got !== exp_rs) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp res=%h st=%0d lt=%b eq=%b got res=%h st=%0d lt=%b eq=%b",
                   exp_rs.result, exp_rs.status, exp_rs.a_less, exp_rs.a_equal,
                   got.result, got.status, got.a_less, got.a_equal);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  request_t request = '0;
  response_t response;
  longint cycles = 0;
  alu_scoreboard board = new();

  fixed_point_alu_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .response(response)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_response(response);
    if (!rst && start && !busy) board.note_request(request);
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 1023)) - 512;
      4: return $signed($urandom_range(0, 65535)) - 32768;
      5: return $signed($urandom_range(0, 1)) ? 32'sd256 : -32'sd256;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic signed [31:0] a, logic signed [31:0] b,
                              int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= '{operation: op, operand_a: a, operand_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [2:0] op;
    logic signed [31:0] ea[5];
    logic signed [31:0] ra, rb;
    bit burst;
    ea = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 32'sd256, -32'sd1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int o = 0; o < 8; o++) begin
      op = 3'(o);
      send_request(op, ea[o % 5], ea[(o + 2) % 5], 0);
    end
    send_request(OP_DIV, 32'sd1000, 32'sd0, 0);
    send_request(OP_DIV, 32'sh8000_0000, -32'sd1, 1);
    send_request(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_request(OP_MUL, -32'sd1, 32'sd128, 0);
    send_request(OP_MUL, 32'sd1, 32'sd128, 0);
    send_request(OP_DIV, 32'sd1, 32'sd512, 2);
    send_request(OP_SUB, 32'sh8000_0000, 32'sd1, 0);
    send_request(OP_ADD, 32'sh7fff_ffff, 32'sd1, 0);
    send_request(OP_MIN, 32'sd5, 32'sd5, 0);
    send_request(OP_MAX, -32'sd5, 32'sd5, 0);
    send_request(OP_DIV, 32'sh7fff_ffff, 32'sd1, 0);
    send_request(OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) burst = 1'($urandom_range(0, 1));
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ra = pick_operand();
      rb = ($urandom_range(0, 7) == 0) ? ra : pick_operand();
      send_request(op, ra, rb, burst ? 0 : int'($urandom_range(0, 18)));
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[fixed_point_alu_core.f]
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_core.sv
dv/fixed_point_alu_core_tb.sv
